FILE: rtl/wfbm_pkg.sv
// shared constants, widths and helper functions for the warped fbm noise block
package wfbm_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int IN_W = 24;
  localparam int CW = IN_W + 1;
  localparam int SCL_W = 20;
  localparam int SW = CW + 3;
  localparam int LAT_W = SW - COORD_FRAC_BITS;
  localparam int NUM_OCT = 3;
  localparam int FBM_STAGES = 8;
  localparam int NSTG = 1 + 2 * FBM_STAGES;
  localparam int WARP_SHIFT = 23 - COORD_FRAC_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WARP_STRENGTH = CFG_IDX_W'(1);

  localparam logic [31:0] HK1 = 32'd374761393;
  localparam logic [31:0] HK2 = 32'd668265263;
  localparam logic [31:0] HK3 = 32'd2147483647;
  localparam logic [31:0] HK4 = 32'd1274126177;

  localparam logic [31:0] SCALE_Q16 [NUM_OCT] = '{32'd65536, 32'd137626, 32'd281805};
  localparam logic [31:0] OCT_SEED [NUM_OCT] = '{32'h0, 32'h9E37, 32'h79B9};
  localparam logic [15:0] OCT_WEIGHT [NUM_OCT] = '{16'd36045, 16'd19661, 16'd9830};

  localparam logic [31:0] SEED_A = 32'hA341;
  localparam logic [31:0] SEED_B = 32'h5C1D;

  localparam logic [17:0] T_BASE = 18'd196608;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  function automatic logic [31:0] to_coord(input logic [31:0] q16);
    logic [33:0] v;
    v = (34'(q16) * 34'd2 + (34'd1 << (16 - COORD_FRAC_BITS))) >> (17 - COORD_FRAC_BITS);
    return v[31:0];
  endfunction

  localparam logic signed [CW-1:0] OFF_AX = CW'(to_coord(32'd897843));
  localparam logic signed [CW-1:0] OFF_AY = CW'(to_coord(32'd268698));
  localparam logic signed [CW-1:0] OFF_BX = CW'(to_coord(32'd478413));
  localparam logic signed [CW-1:0] OFF_BY = CW'(to_coord(32'd1435238));

  function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [16:0] s);
    logic [33:0] acc;
    acc = 34'(a) * 34'(ONE_Q16 - s) + 34'(b) * 34'(s);
    return acc[31:16];
  endfunction

endpackage

FILE: rtl/warped_fbm_value_noise.sv
// warped fbm value noise: domain warp by two fbm fields, then final fbm
// One request on the input channel carries a signed fixed-point coordinate
// pair (x_coord, y_coord); one request on the output channel carries the
// noise sample noise_value. A request moves when valid is high and stall low.
// Configuration registers (noise seed, warp strength) are written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high
// and writes belong in idle time. Unknown indexes are ignored.
// Throughput: one sample per cycle while the receiver does not stall. The
// result passes through one input stage, eight stages for the two warp fbm
// units running side by side and eight for the final fbm unit, whose last
// stage is the output register.
// When the receiver stalls, valid bits keep their data and empty stages in
// front still fill, so input is refused only once all 17 stages hold data.
// Synchronous reset clears all valid bits and sets both registers to zero.
module warped_fbm_value_noise (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [wfbm_pkg::IN_W-1:0]   x_coord,
  input  logic signed [wfbm_pkg::IN_W-1:0]   y_coord,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        noise_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wfbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import wfbm_pkg::*;

  logic [31:0] noise_seed;
  logic [11:0] warp_strength;
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic signed [IN_W-1:0] x0;
  logic signed [IN_W-1:0] y0;
  logic signed [IN_W-1:0] xdl [FBM_STAGES];
  logic signed [IN_W-1:0] ydl [FBM_STAGES];
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic [15:0] fa_val;
  logic [15:0] fb_val;
  logic signed [16:0] qx;
  logic signed [16:0] qy;
  logic signed [29:0] wpx;
  logic signed [29:0] wpy;
  logic signed [CW-1:0] fin_x;
  logic signed [CW-1:0] fin_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed    <= '0;
      warp_strength <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NOISE_SEED:    noise_seed <= cfg_data;
        REG_WARP_STRENGTH: warp_strength <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // per-stage advance, bubbles collapse
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0 <= x_coord;
      y0 <= y_coord;
    end
    if (rdy[1]) begin
      xdl[0] <= x0;
      ydl[0] <= y0;
    end
    for (int k = 1; k < FBM_STAGES; k++) begin
      if (rdy[k+1]) begin
        xdl[k] <= xdl[k-1];
        ydl[k] <= ydl[k-1];
      end
    end
  end

  assign ax = CW'(x0) + OFF_AX;
  assign ay = CW'(y0) + OFF_AY;
  assign bx = CW'(x0) - OFF_BX;
  assign by = CW'(y0) + OFF_BY;

  wfbm_fbm u_fbm_a (
    .clk   (clk),
    .adv   (rdy[FBM_STAGES:1]),
    .seed  (noise_seed ^ SEED_A),
    .x_in  (ax),
    .y_in  (ay),
    .value (fa_val)
  );

  wfbm_fbm u_fbm_b (
    .clk   (clk),
    .adv   (rdy[FBM_STAGES:1]),
    .seed  (noise_seed ^ SEED_B),
    .x_in  (bx),
    .y_in  (by),
    .value (fb_val)
  );

  // warp offset
  assign qx    = $signed({1'b0, fa_val}) - 17'sd32768;
  assign qy    = $signed({1'b0, fb_val}) - 17'sd32768;
  assign wpx   = 30'($signed({1'b0, warp_strength})) * 30'(qx);
  assign wpy   = 30'($signed({1'b0, warp_strength})) * 30'(qy);
  assign fin_x = CW'(xdl[FBM_STAGES-1]) + CW'(wpx >>> WARP_SHIFT);
  assign fin_y = CW'(ydl[FBM_STAGES-1]) + CW'(wpy >>> WARP_SHIFT);

  wfbm_fbm u_fbm_final (
    .clk   (clk),
    .adv   (rdy[2*FBM_STAGES:FBM_STAGES+1]),
    .seed  (noise_seed),
    .x_in  (fin_x),
    .y_in  (fin_y),
    .value (noise_value)
  );

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input refused while pipeline has a free stage");

  a_out_from_prev: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[NSTG-1]) |-> $past(vld[NSTG-2]))
    else $error("output valid without data in previous stage");

  a_take_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted request not captured");

  a_no_warp: assert property (@(posedge clk) disable iff (rst)
    vld[FBM_STAGES] && warp_strength == 12'd0 |->
      (fin_x == CW'(xdl[FBM_STAGES-1]) && fin_y == CW'(ydl[FBM_STAGES-1])))
    else $error("nonzero offset with zero warp strength");
`endif

endmodule

FILE: rtl/wfbm_fbm.sv
// pipelined three-octave fbm value noise unit, eight register stages
module wfbm_fbm (
  input  logic                                clk,
  input  logic [wfbm_pkg::FBM_STAGES-1:0]     adv,
  input  logic [31:0]                         seed,
  input  logic signed [wfbm_pkg::CW-1:0]      x_in,
  input  logic signed [wfbm_pkg::CW-1:0]      y_in,
  output logic [15:0]                         value
);
  import wfbm_pkg::*;

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [15:0] vn [NUM_OCT];
  logic [31:0] wsum;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cx <= x_in;
      cy <= y_in;
    end
  end

  for (genvar o = 0; o < NUM_OCT; o++) begin : g_oct
    logic signed [SW-1:0] scx;
    logic signed [SW-1:0] scy;
    logic [31:0] xi32;
    logic [31:0] yi32;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [31:0] fxx;
    logic [31:0] fyy;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] hs;
    logic [15:0] fxr;
    logic [15:0] fyr;
    logic [15:0] f2x;
    logic [15:0] f2y;
    logic [31:0] base;
    logic [31:0] hm [4];
    logic [31:0] hp [4];
    logic [15:0] cv [4];
    logic [31:0] cadd [4];
    logic [33:0] spx;
    logic [33:0] spy;
    logic [16:0] smx;
    logic [16:0] smy;
    logic [16:0] smx4;
    logic [16:0] smy4;
    logic [16:0] smy5;
    logic [15:0] r0;
    logic [15:0] r1;

    if (o == 0) begin : g_unit
      always_ff @(posedge clk) begin
        if (adv[1]) begin
          scx <= SW'(cx);
          scy <= SW'(cy);
        end
      end
    end else begin : g_scaled
      logic signed [CW+SCL_W-1:0] px;
      logic signed [CW+SCL_W-1:0] py;
      assign px = cx * $signed(SCL_W'(SCALE_Q16[o]));
      assign py = cy * $signed(SCL_W'(SCALE_Q16[o]));
      always_ff @(posedge clk) begin
        if (adv[1]) begin
          scx <= SW'(px >>> 16);
          scy <= SW'(py >>> 16);
        end
      end
    end

    // lattice cell and fraction
    assign xi32 = 32'($signed(scx[SW-1:COORD_FRAC_BITS]));
    assign yi32 = 32'($signed(scy[SW-1:COORD_FRAC_BITS]));
    assign fx = 16'(scx[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
    assign fy = 16'(scy[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
    assign fxx = 32'(fx) * 32'(fx);
    assign fyy = 32'(fy) * 32'(fy);

    always_ff @(posedge clk) begin
      if (adv[2]) begin
        ha  <= xi32 * HK1;
        hb  <= yi32 * HK2;
        hs  <= (seed ^ OCT_SEED[o]) * HK3;
        fxr <= fx;
        fyr <= fy;
        f2x <= fxx[31:16];
        f2y <= fyy[31:16];
      end
    end

    // corner order 00, 10, 01, 11
    assign base = ha + hb + hs;
    assign cadd[0] = 32'd0;
    assign cadd[1] = HK1;
    assign cadd[2] = HK2;
    assign cadd[3] = HK1 + HK2;
    assign spx = 34'(f2x) * 34'(T_BASE - {1'b0, fxr, 1'b0});
    assign spy = 34'(f2y) * 34'(T_BASE - {1'b0, fyr, 1'b0});

    always_ff @(posedge clk) begin
      if (adv[3]) begin
        for (int c = 0; c < 4; c++) begin
          hm[c] <= (base + cadd[c]) ^ ((base + cadd[c]) >> 13);
        end
        smx <= spx[32:16];
        smy <= spy[32:16];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[4]) begin
        for (int c = 0; c < 4; c++) begin
          hp[c] <= hm[c] * HK4;
        end
        smx4 <= smx;
        smy4 <= smy;
      end
    end

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        cv[c] = hp[c][15:0] ^ hp[c][31:16];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[5]) begin
        r0   <= blend16(cv[0], cv[1], smx4);
        r1   <= blend16(cv[2], cv[3], smx4);
        smy5 <= smy4;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[6]) begin
        vn[o] <= blend16(r0, r1, smy5);
      end
    end
  end

  always_comb begin
    wsum = '0;
    for (int k = 0; k < NUM_OCT; k++) begin
      wsum = wsum + 32'(vn[k]) * 32'(OCT_WEIGHT[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      value <= wsum[31:16];
    end
  end

endmodule
